@@ hdl/unsigned_number_parser_suffix_assert.svh @@
// Assertion macros used by the number parser top level.
`ifndef UNSIGNED_NUMBER_PARSER_SUFFIX_ASSERT_SVH
`define UNSIGNED_NUMBER_PARSER_SUFFIX_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define UNPS_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("unps assertion failed");

// Next-cycle implication, disabled during reset.
`define UNPS_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("unps assertion failed");

`endif

@@ hdl/unps_pkg.sv @@
// Package: types, constants and helpers for the number parser.
`timescale 1ns / 1ps
package unps_pkg;

   localparam int VALUE_W = 32;
   localparam int OFF_W   = 8;
   localparam int BASE_W  = 5;
   localparam int SHIFT_W = 5;
   localparam int DIGIT_W = 6;

   localparam logic [OFF_W-1:0]   MAX_LEN   = 8'd255;
   localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

   localparam logic [SHIFT_W-1:0] SHIFT_R = 5'd13;
   localparam logic [SHIFT_W-1:0] SHIFT_K = 5'd10;
   localparam logic [SHIFT_W-1:0] SHIFT_M = 5'd20;
   localparam logic [SHIFT_W-1:0] SHIFT_G = 5'd30;

   localparam logic [BASE_W-1:0] BASE_NONE = 5'd0;
   localparam logic [BASE_W-1:0] BASE_ONE  = 5'd1;
   localparam logic [BASE_W-1:0] BASE_BIN  = 5'd2;
   localparam logic [BASE_W-1:0] BASE_OCT  = 5'd8;
   localparam logic [BASE_W-1:0] BASE_DEC  = 5'd10;
   localparam logic [BASE_W-1:0] BASE_HEX  = 5'd16;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_1     = 8'h31;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UX    = 8'h58;
   localparam logic [7:0] CH_UZ    = 8'h5A;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LB    = 8'h62;
   localparam logic [7:0] CH_LG    = 8'h67;
   localparam logic [7:0] CH_LK    = 8'h6B;
   localparam logic [7:0] CH_LM    = 8'h6D;
   localparam logic [7:0] CH_LR    = 8'h72;
   localparam logic [7:0] CH_LX    = 8'h78;
   localparam logic [7:0] CH_LZ    = 8'h7A;
   localparam logic [7:0] CASE_GAP = 8'h20;

   localparam logic [DIGIT_W-1:0] DIGIT_NONE = '1;
   localparam logic [DIGIT_W-1:0] DIGIT_HEX  = 6'd16;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_ACTIVE,
      PH_ENDED
   } phase_type;

   typedef enum logic [2:0] {
      CV_WS,
      CV_SIGNED,
      CV_ZERO,
      CV_XSEEN,
      CV_DIGITS,
      CV_DONE
   } conv_type;

   typedef struct packed {
      phase_type            phase;
      conv_type             conv;
      logic [VALUE_W-1:0]   acc;
      logic [BASE_W-1:0]    base_in_use;
      logic [BASE_W-1:0]    conv_base;
      logic                 negative;
      logic                 saturated;
      logic [OFF_W-1:0]     position;
      logic [OFF_W-1:0]     stop_pos;
      logic [OFF_W-1:0]     start_off;
      logic                 run_started;
      logic                 scan_done;
      logic [SHIFT_W-1:0]   shift;
      logic                 digit_seen;
   } parse_state_type;

   // Everything the output stage needs to form one result.
   typedef struct packed {
      logic [VALUE_W-1:0] acc;
      logic               negative;
      logic               saturated;
      logic [SHIFT_W-1:0] shift;
      logic [OFF_W-1:0]   end_offset;
      logic               converted;
   } snap_type;

   function automatic logic [DIGIT_W-1:0] digit_val(input logic [7:0] c);
      logic [DIGIT_W-1:0] d;
      d = DIGIT_NONE;
      if (c >= CH_0 && c <= CH_9) d = DIGIT_W'(c - CH_0);
      else if (c >= CH_LA && c <= CH_LZ) d = DIGIT_W'(c - CH_LA + 8'd10);
      else if (c >= CH_UA && c <= CH_UZ) d = DIGIT_W'(c - CH_UA + 8'd10);
      return d;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic logic [OFF_W-1:0] off_inc(input logic [OFF_W-1:0] p);
      return (p >= MAX_LEN) ? MAX_LEN : p + 1'b1;
   endfunction

endpackage

@@ hdl/unps_parse.sv @@
// Per-character parse state and its registered update.
`timescale 1ns / 1ps
module unps_parse
   import unps_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         item_valid,
   input  logic [7:0]   ch,
   input  logic         first,
   input  logic         last,
   input  logic [4:0]   radix,
   output logic         emit,
   output snap_type     snap
);

   parse_state_type state_ff;
   parse_state_type state_in;
   parse_state_type start_val;

   always_comb begin
      start_val             = '0;
      start_val.phase       = PH_IDLE;
      start_val.conv        = CV_WS;
   end

   always_comb begin
      parse_state_type    s;
      logic [DIGIT_W-1:0] d;
      logic [7:0]         lc;
      logic [OFF_W-1:0]   p;
      logic               feed;
      logic               handled;
      logic               do_acc;
      logic               in_run;
      logic [VALUE_W+BASE_W:0] prod;

      s       = state_ff;
      feed    = 1'b0;
      handled = 1'b0;
      do_acc  = 1'b0;
      in_run  = 1'b0;
      prod    = '0;
      emit    = 1'b0;
      d       = digit_val(ch);
      lc      = (ch >= CH_UA && ch <= CH_UZ) ? ch + CASE_GAP : ch;
      p       = state_ff.position;

      if (first) begin
         s             = start_val;
         s.phase       = PH_ACTIVE;
         s.base_in_use = radix;
         s.conv_base   = radix;
         s.conv        = (radix == BASE_ONE) ? CV_DONE : CV_WS;
         p             = '0;
      end

      if (s.phase != PH_IDLE) begin
         if (s.phase == PH_ACTIVE) begin
            if (ch == CH_NUL) begin
               if (!s.run_started) s.start_off = p;
               s.phase = PH_ENDED;
            end else begin
               feed = 1'b1;
               if (!s.run_started) begin
                  if (ch == CH_SPACE || ch == CH_TAB) begin
                     feed = 1'b0;
                  end else if (s.base_in_use == BASE_NONE && ch == CH_LB) begin
                     s.base_in_use = BASE_BIN;
                     s.conv_base   = BASE_BIN;
                     s.start_off   = off_inc(p);
                     s.run_started = 1'b1;
                     feed          = 1'b0;
                  end else begin
                     s.start_off   = p;
                     s.run_started = 1'b1;
                  end
               end

               if (feed) begin
                  // suffix run: hex digits and x/X (binary: 0/1)
                  if (!s.scan_done) begin
                     if (s.base_in_use == BASE_BIN) in_run = (ch == CH_0 || ch == CH_1);
                     else in_run = (d < DIGIT_HEX) || ch == CH_LX || ch == CH_UX;
                     if (!in_run) begin
                        case (lc)
                           CH_LR:   s.shift = SHIFT_R;
                           CH_LK:   s.shift = SHIFT_K;
                           CH_LM:   s.shift = SHIFT_M;
                           CH_LG:   s.shift = SHIFT_G;
                           default: s.shift = '0;
                        endcase
                        s.scan_done = 1'b1;
                     end
                  end

                  // conversion sequencer
                  if (s.conv != CV_DONE) begin
                     if (s.conv == CV_WS) begin
                        if (is_space(ch)) begin
                           handled = 1'b1;
                        end else begin
                           s.conv = CV_SIGNED;
                           if (ch == CH_PLUS) begin
                              handled = 1'b1;
                           end else if (ch == CH_MINUS) begin
                              s.negative = 1'b1;
                              handled    = 1'b1;
                           end
                        end
                     end
                     if (!handled && s.conv == CV_SIGNED) begin
                        if (ch == CH_0 &&
                            (s.conv_base == BASE_NONE || s.conv_base == BASE_HEX)) begin
                           s.digit_seen = 1'b1;
                           s.acc        = '0;
                           s.stop_pos   = off_inc(p);
                           s.conv       = CV_ZERO;
                        end else begin
                           if (s.conv_base == BASE_NONE) s.conv_base = BASE_DEC;
                           do_acc = 1'b1;
                        end
                     end else if (!handled && s.conv == CV_ZERO) begin
                        if (ch == CH_LX || ch == CH_UX) begin
                           s.conv = CV_XSEEN;
                        end else begin
                           if (s.conv_base == BASE_NONE) s.conv_base = BASE_OCT;
                           do_acc = 1'b1;
                        end
                     end else if (!handled && s.conv == CV_XSEEN) begin
                        if (d < DIGIT_HEX) begin
                           s.conv_base = BASE_HEX;
                           do_acc      = 1'b1;
                        end else begin
                           s.conv = CV_DONE;
                        end
                     end else if (!handled) begin
                        do_acc = 1'b1;
                     end
                  end

                  if (do_acc) begin
                     if (s.conv_base < BASE_BIN || {1'b0, d} >= {2'b0, s.conv_base}) begin
                        s.conv = CV_DONE;
                     end else begin
                        if (!s.saturated) begin
                           prod = (VALUE_W+BASE_W+1)'(s.acc) * (VALUE_W+BASE_W+1)'(s.conv_base)
                                + (VALUE_W+BASE_W+1)'(d);
                           if (prod[VALUE_W+BASE_W:VALUE_W] != '0) begin
                              s.saturated = 1'b1;
                              s.acc       = VALUE_MAX;
                           end else begin
                              s.acc = prod[VALUE_W-1:0];
                           end
                        end
                        s.digit_seen = 1'b1;
                        s.stop_pos   = off_inc(p);
                        s.conv       = CV_DIGITS;
                     end
                  end
               end

               if (last) begin
                  if (!s.run_started) s.start_off = off_inc(p);
                  s.phase = PH_ENDED;
               end
            end
         end
         s.position = off_inc(p);
         if (last) begin
            emit    = 1'b1;
            s.phase = PH_IDLE;
         end
      end

      snap.acc        = s.acc;
      snap.negative   = s.negative;
      snap.saturated  = s.saturated;
      snap.shift      = s.shift;
      snap.end_offset = s.digit_seen ? s.stop_pos : s.start_off;
      snap.converted  = s.digit_seen;
      state_in        = item_valid ? s : state_ff;
      emit            = emit & item_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= start_val;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hdl/unsigned_number_parser_suffix.sv @@
// Top level: streaming unsigned number parser with r/k/m/g size suffix.
//
// Usage: characters of a string arrive on the req_ channel, one per
// transaction; req_first opens a string and samples req_radix (0 detects
// the base from the prefix, a leading 'b' selects binary), req_last closes
// it. One rsp_ transaction follows each closed string that was opened:
// the value after the suffix shift, the end offset, the overflow flag and
// whether any digit was converted. Characters outside a string are dropped.
// The last character passes through the input register, the parse stage
// and the output register before the result is valid.
// One character per cycle unless stalled; the parse stage updates its state
// with one 32x5 multiply-add per character, which sets the clock period.
// A stalled rsp_ready backs up the pipeline one stage at a time; up to two
// results and one character are held before req_ready drops.
// Reset (synchronous, active high) empties all stages and closes any open
// string; the first character after reset must carry req_first.
`timescale 1ns / 1ps
`include "unsigned_number_parser_suffix_assert.svh"
module unsigned_number_parser_suffix
   import unps_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_ch,
   input  logic                req_first,
   input  logic                req_last,
   input  logic [4:0]          req_radix,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [VALUE_W-1:0]  rsp_value,
   output logic [OFF_W-1:0]    rsp_end_offset,
   output logic                rsp_overflow,
   output logic                rsp_converted
);

   logic               a_valid_ff, a_valid_in;
   logic [7:0]         a_ch_ff;
   logic               a_first_ff;
   logic               a_last_ff;
   logic [4:0]         a_radix_ff;
   logic               b_valid_ff, b_valid_in;
   snap_type           b_snap_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [OFF_W-1:0]   rsp_end_offset_ff;
   logic               rsp_overflow_ff;
   logic               rsp_converted_ff;

   logic               req_take;
   logic               a_adv;
   logic               b_adv;
   logic               emit;
   snap_type           snap;
   logic [VALUE_W-1:0] signed_val;

   assign b_adv     = b_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign a_adv     = a_valid_ff && (!b_valid_ff || b_adv);
   assign req_ready = !a_valid_ff || a_adv;
   assign req_take  = req_valid && req_ready;

   assign a_valid_in   = req_take || (a_valid_ff && !a_adv);
   assign b_valid_in   = (a_adv && emit) || (b_valid_ff && !b_adv);
   assign rsp_valid_in = b_adv || (rsp_valid_ff && !rsp_ready);

   unps_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .item_valid (a_adv),
      .ch         (a_ch_ff),
      .first      (a_first_ff),
      .last       (a_last_ff),
      .radix      (a_radix_ff),
      .emit       (emit),
      .snap       (snap)
   );

   // saturated accumulator already holds all ones, so negation is skipped
   always_comb begin
      if (b_snap_ff.saturated) signed_val = VALUE_MAX;
      else if (b_snap_ff.negative) signed_val = VALUE_W'(0) - b_snap_ff.acc;
      else signed_val = b_snap_ff.acc;
      rsp_value_in = signed_val << b_snap_ff.shift;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         b_valid_ff   <= b_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         a_ch_ff    <= req_ch;
         a_first_ff <= req_first;
         a_last_ff  <= req_last;
         a_radix_ff <= req_radix;
      end
      if (a_adv && emit) begin
         b_snap_ff <= snap;
      end
      if (b_adv) begin
         rsp_value_ff      <= rsp_value_in;
         rsp_end_offset_ff <= b_snap_ff.end_offset;
         rsp_overflow_ff   <= b_snap_ff.saturated;
         rsp_converted_ff  <= b_snap_ff.converted;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_value      = rsp_value_ff;
   assign rsp_end_offset = rsp_end_offset_ff;
   assign rsp_overflow   = rsp_overflow_ff;
   assign rsp_converted  = rsp_converted_ff;

   `UNPS_ASSERT_NEXT(a_held_on_stall, clock, reset, a_valid_ff && !a_adv, a_valid_ff)
   `UNPS_ASSERT_NEXT(b_held_on_stall, clock, reset, b_valid_ff && !b_adv, b_valid_ff)
   `UNPS_ASSERT_NOW(sat_means_all_ones, clock, reset,
      b_valid_ff && b_snap_ff.saturated, b_snap_ff.acc == VALUE_MAX)
   `UNPS_ASSERT_NOW(no_digit_zero_value, clock, reset,
      rsp_valid_ff && !rsp_converted_ff, rsp_value_ff == '0 && !rsp_overflow_ff)

endmodule
